// ===== rtl/tthp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tthp_pkg
// Shared types, constants and helper functions of the turn-to-heading
// proportional controller.
// ----------------------------------------------------------------------------
package tthp_pkg;

  // Angle constants in 1/64 degree
  localparam int HALF_TURN  = 11520;
  localparam int FULL_TURN  = 23040;
  localparam int FULL_SCALE = 4096;
  localparam int PWM_MAX    = 255;
  localparam int COUNT_MAX  = 255;

  // Register defaults
  localparam logic signed [15:0] TARGET_HEADING_RST   = 16'sd0;
  localparam logic [15:0]        TURN_GAIN_RST        = 16'd410;
  localparam logic [12:0]        DRIVE_LIMIT_RST      = 13'd2048;
  localparam logic [13:0]        SETTLE_TOLERANCE_RST = 14'd384;
  localparam logic [7:0]         SETTLE_LIMIT_RST     = 8'd15;
  localparam logic [15:0]        TIMEOUT_MS_RST       = 16'd4000;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_HEADING   = 3'd0,
    REG_TURN_GAIN        = 3'd1,
    REG_DRIVE_LIMIT      = 3'd2,
    REG_SETTLE_TOLERANCE = 3'd3,
    REG_SETTLE_LIMIT     = 3'd4,
    REG_TIMEOUT_MS       = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic signed [15:0] target_heading;
    logic [15:0]        turn_gain;
    logic [12:0]        drive_limit;
    logic [13:0]        settle_tolerance;
    logic [7:0]         settle_limit;
    logic [15:0]        timeout_ms;
  } cfg_t;

  typedef enum logic {
    CMD_START  = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    DIR_FWD   = 2'd0,
    DIR_REV   = 2'd1,
    DIR_BRAKE = 2'd2
  } dir_t;

  typedef enum logic [1:0] {
    ST_STARTED = 2'd0,
    ST_TURNING = 2'd1,
    ST_SETTLED = 2'd2,
    ST_TIMEOUT = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_TURNING = 2'd1,
    PH_SETTLED = 2'd2,
    PH_TIMEOUT = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WRAP1,
    S_WRAP2,
    S_MUL_GAIN,
    S_MUL_PWM,
    S_DONE
  } seq_state_t;

  typedef enum logic {
    MUL_GAIN,
    MUL_PWM
  } mul_sel_t;

  typedef struct packed {
    mul_sel_t    sel;
    logic [15:0] gain;
    logic [13:0] mag;
    logic [12:0] drv;
  } mul_req_t;

  typedef struct packed {
    dir_t       dir;
    logic [7:0] pwm;
  } drive_t;

  // One wrap step: x - trunc((x + off) / FULL_TURN) * FULL_TURN, quotient
  // found by comparing the magnitude against the few reachable multiples.
  function automatic logic signed [17:0] wrap_step(input logic signed [17:0] x,
                                                   input logic signed [17:0] off);
    logic signed [18:0] v;
    logic [18:0]        mag;
    logic               neg;
    logic [17:0]        d;
    v   = {x[17], x} + {off[17], off};
    neg = v[18];
    mag = neg ? 19'(-v) : 19'(v);
    if (mag >= 19'(3 * FULL_TURN)) begin
      d = 18'(3 * FULL_TURN);
    end else if (mag >= 19'(2 * FULL_TURN)) begin
      d = 18'(2 * FULL_TURN);
    end else if (mag >= 19'(FULL_TURN)) begin
      d = 18'(FULL_TURN);
    end else begin
      d = 18'd0;
    end
    return neg ? 18'(x + $signed(d)) : 18'(x - $signed(d));
  endfunction

  function automatic drive_t pack_drive(input logic negative, input logic [7:0] pwm);
    drive_t r;
    r.pwm = pwm;
    if (pwm == 8'd0) begin
      r.dir = DIR_BRAKE;
    end else if (negative) begin
      r.dir = DIR_REV;
    end else begin
      r.dir = DIR_FWD;
    end
    return r;
  endfunction

endpackage

// ===== rtl/tthp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tthp_if
// Valid/ready channels of the turn-to-heading controller: the command and
// sample channel, and the result channel.
// ----------------------------------------------------------------------------
interface tthp_in_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic signed [15:0] measured_heading;
  logic [31:0]        now_ms;

  modport source (output valid, cmd, measured_heading, now_ms, input ready);
  modport sink   (input valid, cmd, measured_heading, now_ms, output ready);
endinterface

interface tthp_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [1:0]         left_dir;
  logic [7:0]         left_pwm;
  logic [1:0]         right_dir;
  logic [7:0]         right_pwm;
  logic signed [14:0] heading_error;

  modport source (output valid, status, left_dir, left_pwm, right_dir, right_pwm,
                  heading_error, input ready);
  modport sink   (input valid, status, left_dir, left_pwm, right_dir, right_pwm,
                  heading_error, output ready);
endinterface

// ===== rtl/tthp_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tthp_cfg_regs
// Configuration register file: decodes the write port into the six
// controller registers.
// ----------------------------------------------------------------------------
module tthp_cfg_regs
  import tthp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_heading   <= TARGET_HEADING_RST;
      cfg.turn_gain        <= TURN_GAIN_RST;
      cfg.drive_limit      <= DRIVE_LIMIT_RST;
      cfg.settle_tolerance <= SETTLE_TOLERANCE_RST;
      cfg.settle_limit     <= SETTLE_LIMIT_RST;
      cfg.timeout_ms       <= TIMEOUT_MS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TARGET_HEADING:   cfg.target_heading   <= $signed(cfg_data);
        REG_TURN_GAIN:        cfg.turn_gain        <= cfg_data;
        REG_DRIVE_LIMIT:      cfg.drive_limit      <= cfg_data[12:0];
        REG_SETTLE_TOLERANCE: cfg.settle_tolerance <= cfg_data[13:0];
        REG_SETTLE_LIMIT:     cfg.settle_limit     <= cfg_data[7:0];
        REG_TIMEOUT_MS:       cfg.timeout_ms       <= cfg_data;
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

endmodule

// ===== rtl/tthp_mul_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tthp_mul_unit
// Shared 16 x 16 unsigned multiplier: gain times error magnitude, or
// clamped drive times the PWM full count.
// ----------------------------------------------------------------------------
module tthp_mul_unit
  import tthp_pkg::*;
(
  input  mul_req_t    req,
  output logic [31:0] prod
);

  logic [15:0] op_a;
  logic [15:0] op_b;

  always_comb begin
    case (req.sel)
      MUL_GAIN: begin
        op_a = req.gain;
        op_b = {2'b00, req.mag};
      end
      default: begin
        op_a = {3'b000, req.drv};
        op_b = 16'(PWM_MAX);
      end
    endcase
  end

  assign prod = op_a * op_b;

endmodule

// ===== rtl/tthp_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tthp_ctrl
// Sequencer and datapath: phase tracking, two-step angle wrap, gain and PWM
// scaling through the shared multiplier, settle counting, result register.
// ----------------------------------------------------------------------------
module tthp_ctrl
  import tthp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  tthp_in_if.sink     in_ch,
  tthp_out_if.source  out_ch,
  output mul_req_t    mul_req,
  input  logic [31:0] mul_prod
);

  seq_state_t state, state_next;

  logic [31:0]        start_time;
  logic [7:0]         count;
  phase_t             phase;
  drive_t             left_drive;
  drive_t             right_drive;
  logic signed [14:0] last_error;

  logic signed [17:0] t;
  logic               neg;
  logic [13:0]        mag;
  logic [12:0]        drv;
  status_t            status;

  logic               out_valid;
  status_t            out_status;
  drive_t             out_left;
  drive_t             out_right;
  logic signed [14:0] out_error;

  logic               accept;
  logic               out_free;
  logic               timed_out;
  logic [31:0]        elapsed;
  logic [12:0]        lim;
  logic [25:0]        drv_raw;
  logic signed [17:0] t_wrapped;
  logic [7:0]         pwm;
  logic [7:0]         count_next;

  assign in_ch.ready = (state == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid || out_ch.ready;
  assign elapsed     = in_ch.now_ms - start_time;
  assign timed_out   = elapsed > {16'd0, cfg.timeout_ms};
  assign lim         = (cfg.drive_limit > 13'(FULL_SCALE)) ? 13'(FULL_SCALE)
                                                           : cfg.drive_limit;
  assign drv_raw     = mul_prod[31:6];
  assign t_wrapped   = wrap_step(t, -18'sd11520);
  assign pwm         = mul_prod[19:12];

  always_comb begin
    count_next = count;
    if (({4'd0, mag} < {4'd0, cfg.settle_tolerance}) && (count != 8'(COUNT_MAX))) begin
      count_next = count + 8'd1;
    end
  end

  always_comb begin
    mul_req.sel  = (state == S_MUL_GAIN) ? MUL_GAIN : MUL_PWM;
    mul_req.gain = cfg.turn_gain;
    mul_req.mag  = mag;
    mul_req.drv  = drv;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_ch.cmd == CMD_START || phase != PH_TURNING || timed_out) begin
            state_next = S_DONE;
          end else begin
            state_next = S_WRAP1;
          end
        end
      end
      S_WRAP1:    state_next = S_WRAP2;
      S_WRAP2:    state_next = S_MUL_GAIN;
      S_MUL_GAIN: state_next = S_MUL_PWM;
      S_MUL_PWM:  state_next = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default:    state_next = S_IDLE;
    endcase
  end

  // Turn state and working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_time  <= 32'd0;
      count       <= 8'd0;
      phase       <= PH_IDLE;
      left_drive  <= '{dir: DIR_BRAKE, pwm: 8'd0};
      right_drive <= '{dir: DIR_BRAKE, pwm: 8'd0};
      last_error  <= 15'sd0;
      status      <= ST_STARTED;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (in_ch.cmd == CMD_START) begin
              start_time <= in_ch.now_ms;
              count      <= 8'd0;
              phase      <= PH_TURNING;
              status     <= ST_STARTED;
            end else begin
              case (phase)
                PH_IDLE:    status <= ST_TIMEOUT;
                PH_SETTLED: status <= ST_SETTLED;
                PH_TIMEOUT: status <= ST_TIMEOUT;
                default: begin
                  if (timed_out) begin
                    phase  <= PH_TIMEOUT;
                    status <= ST_TIMEOUT;
                  end
                end
              endcase
            end
          end
        end
        S_MUL_PWM: begin
          right_drive <= pack_drive(neg, pwm);
          left_drive  <= pack_drive(!neg, pwm);
          last_error  <= t[14:0];
          count       <= count_next;
          if (count_next > cfg.settle_limit) begin
            phase  <= PH_SETTLED;
            status <= ST_SETTLED;
          end else begin
            status <= ST_TURNING;
          end
        end
        default: ;
      endcase
    end
  end

  // Wrap and scaling pipeline registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        t <= {{2{cfg.target_heading[15]}}, cfg.target_heading}
           - {{2{in_ch.measured_heading[15]}}, in_ch.measured_heading};
      end
      S_WRAP1: t <= wrap_step(t, 18'sd11520);
      S_WRAP2: begin
        t   <= t_wrapped;
        neg <= t_wrapped[17];
        mag <= t_wrapped[17] ? 14'(-t_wrapped) : t_wrapped[13:0];
      end
      S_MUL_GAIN: begin
        // clamp before the PWM scaling pass
        drv <= (drv_raw > {13'd0, lim}) ? lim : drv_raw[12:0];
      end
      default: ;
    endcase
  end

  // Result register: hold until the receiver takes the transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      out_status <= status;
      out_left   <= left_drive;
      out_right  <= right_drive;
      out_error  <= last_error;
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.status        = out_status;
  assign out_ch.left_dir      = out_left.dir;
  assign out_ch.left_pwm      = out_left.pwm;
  assign out_ch.right_dir     = out_right.dir;
  assign out_ch.right_pwm     = out_right.pwm;
  assign out_ch.heading_error = out_error;

endmodule

// ===== rtl/turn_to_heading_p_controller_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// turn_to_heading_p_controller_top
// Proportional turn-to-heading controller for a differential drive.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one transaction per command: cmd 0 starts a turn and
//   latches now_ms, cmd 1 is a gyro sample with measured_heading.
//   out_ch returns exactly one result per command: status, left and right
//   motor direction and PWM, and the latest wrapped heading error.
//   Registers are written through cfg_we / cfg_index / cfg_data while idle.
// Sequence:
//   A driving sample passes through the idle state in which it is accepted,
//   two wrap steps, the shared multiplier twice (gain scaling, PWM scaling)
//   and a hand-over state, which registers its result on out_ch. Starts,
//   timed-out samples and samples after the turn has ended go from the idle
//   state straight to the hand-over state. in_ch.ready is high only while
//   the sequencer is idle.
// Reset: registers take their defaults, drives brake, phase idle.
// Stall: a result waits in the output register; the next transaction is
//   accepted meanwhile, and its result holds in the sequencer, with
//   in_ch.ready low, until the register frees.
// ----------------------------------------------------------------------------
module turn_to_heading_p_controller_top
  import tthp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  tthp_in_if.sink               in_ch,
  tthp_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t        cfg;
  mul_req_t    mul_req;
  logic [31:0] mul_prod;

  tthp_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tthp_mul_unit u_mul (
    .req  (mul_req),
    .prod (mul_prod)
  );

  tthp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .mul_req  (mul_req),
    .mul_prod (mul_prod)
  );

endmodule

// ===== tb/turn_to_heading_p_controller_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// turn_to_heading_p_controller_top_tb
// Drives start and gyro transactions into the heading controller under
// several register settings and idling patterns. Every returned transaction is
// compared field by field with an inline answer or a cycle-free controller model.
// ----------------------------------------------------------------------------
module turn_to_heading_p_controller_top_tb;
  import tthp_pkg::*;

  typedef struct packed {
    status_t            status;
    dir_t               left_dir;
    logic [7:0]         left_pwm;
    dir_t               right_dir;
    logic [7:0]         right_pwm;
    logic signed [14:0] heading_error;
  } steer_result_t;

  typedef struct packed {
    cmd_t               cmd;
    logic signed [15:0] meas;
    logic [31:0]        now_ms;
    logic               typed;
    steer_result_t      want;
  } stim_row_t;

  localparam int DIRECTED_N = 18;
  localparam int SETTLE_GAP = 20;

  // Rows with typed set carry the answer inline; the rest go through the model.
  localparam stim_row_t DIRECTED [DIRECTED_N] = '{
    '{CMD_SAMPLE, 16'sh7FFF, 32'h0000_0000, 1'b1,
      '{ST_TIMEOUT, DIR_BRAKE, 8'd0, DIR_BRAKE, 8'd0, 15'sd0}},
    '{CMD_START, 16'sh8000, 32'hFFFF_FF00, 1'b1,
      '{ST_STARTED, DIR_BRAKE, 8'd0, DIR_BRAKE, 8'd0, 15'sd0}},
    '{CMD_SAMPLE, 16'sh8000, 32'hFFFF_FF01, 1'b1,
      '{ST_TURNING, DIR_REV, 8'd127, DIR_FWD, 8'd127, 15'sd9728}},
    '{CMD_SAMPLE, 16'sh7FFF, 32'hFFFF_FF02, 1'b0, '0},
    '{CMD_SAMPLE, -16'sd11520, 32'hFFFF_FF03, 1'b0, '0},
    '{CMD_SAMPLE, 16'sd11520, 32'hFFFF_FF04, 1'b0, '0},
    '{CMD_SAMPLE, 16'sd0, 32'hFFFF_FF05, 1'b0, '0},
    '{CMD_SAMPLE, -16'sd1, 32'hFFFF_FF06, 1'b0, '0},
    '{CMD_SAMPLE, 16'sd1, 32'hFFFF_FF07, 1'b0, '0},
    '{CMD_SAMPLE, -16'sd128, 32'hFFFF_FF08, 1'b0, '0},
    '{CMD_SAMPLE, 16'sd384, 32'hFFFF_FF09, 1'b0, '0},
    '{CMD_SAMPLE, 16'sd383, 32'hFFFF_FF0A, 1'b0, '0},
    '{CMD_SAMPLE, 16'sd200, 32'd3744, 1'b0, '0},
    '{CMD_SAMPLE, 16'sd0, 32'd3745, 1'b0, '0},
    '{CMD_SAMPLE, 16'sd0, 32'd3800, 1'b0, '0},
    '{CMD_START, 16'sh1234, 32'd5000, 1'b0, '0},
    '{CMD_SAMPLE, 16'sd0, 32'd5001, 1'b0, '0},
    '{CMD_SAMPLE, 16'sh8000, 32'd5002, 1'b0, '0}
  };

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  tthp_in_if  in_ch ();
  tthp_out_if out_ch ();

  turn_to_heading_p_controller_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Model copy of registers and turn state
  cfg_t               cfg_now;
  logic [31:0]        turn_start_ms;
  int                 on_target_count;
  phase_t             turn_state;
  dir_t               held_left_dir;
  logic [7:0]         held_left_pwm;
  dir_t               held_right_dir;
  logic [7:0]         held_right_pwm;
  logic signed [14:0] held_error;

  steer_result_t steer_q[$];
  int            mismatches;
  int            send_idle_pct;
  int            recv_stall_pct;
  int            hold_off_left;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic dir_t motor_dir(input logic negative, input logic [7:0] pwm);
    if (pwm == 8'd0) begin
      return DIR_BRAKE;
    end
    return negative ? DIR_REV : DIR_FWD;
  endfunction

  function automatic steer_result_t steer_predict(input cmd_t cmd,
                                                  input logic signed [15:0] meas,
                                                  input logic [31:0] now_ms);
    steer_result_t     r;
    status_t           st;
    logic [31:0]       elapsed;
    int                err;
    int                quot;
    int                mag;
    longint unsigned   drv;
    longint unsigned   lim;
    logic [7:0]        pwm;
    elapsed = now_ms - turn_start_ms;
    if (cmd == CMD_START) begin
      turn_start_ms   = now_ms;
      on_target_count = 0;
      turn_state      = PH_TURNING;
      st              = ST_STARTED;
    end else if (turn_state == PH_IDLE) begin
      st = ST_TIMEOUT;
    end else if (turn_state == PH_SETTLED) begin
      st = ST_SETTLED;
    end else if (turn_state == PH_TIMEOUT) begin
      st = ST_TIMEOUT;
    end else if (elapsed > {16'd0, cfg_now.timeout_ms}) begin
      turn_state = PH_TIMEOUT;
      st         = ST_TIMEOUT;
    end else begin
      // two truncating wrap steps into (-180, 180]
      err  = int'(cfg_now.target_heading) - int'(meas);
      quot = (err + HALF_TURN) / FULL_TURN;
      err  = err - quot * FULL_TURN;
      quot = (err - HALF_TURN) / FULL_TURN;
      err  = err - quot * FULL_TURN;
      mag  = (err < 0) ? -err : err;
      lim  = (cfg_now.drive_limit > FULL_SCALE) ? FULL_SCALE : cfg_now.drive_limit;
      drv  = (longint'(cfg_now.turn_gain) * longint'(mag)) >> 6;
      if (drv > lim) begin
        drv = lim;
      end
      pwm            = 8'((drv * PWM_MAX) >> 12);
      held_right_dir = motor_dir(err < 0, pwm);
      held_left_dir  = motor_dir(!(err < 0), pwm);
      held_right_pwm = pwm;
      held_left_pwm  = pwm;
      held_error     = 15'(err);
      if (mag < int'(cfg_now.settle_tolerance) && on_target_count < COUNT_MAX) begin
        on_target_count++;
      end
      if (on_target_count > int'(cfg_now.settle_limit)) begin
        turn_state = PH_SETTLED;
        st         = ST_SETTLED;
      end else begin
        st = ST_TURNING;
      end
    end
    r.status        = st;
    r.left_dir      = held_left_dir;
    r.left_pwm      = held_left_pwm;
    r.right_dir     = held_right_dir;
    r.right_pwm     = held_right_pwm;
    r.heading_error = held_error;
    return r;
  endfunction

  task automatic check_field(input string name, input integer want, input integer got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    steer_result_t want;
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (steer_q.size() == 0) begin
        $error("result transaction with nothing outstanding");
        mismatches++;
      end else begin
        want = steer_q.pop_front();
        check_field("status", want.status, out_ch.status);
        check_field("left_dir", want.left_dir, out_ch.left_dir);
        check_field("left_pwm", want.left_pwm, out_ch.left_pwm);
        check_field("right_dir", want.right_dir, out_ch.right_dir);
        check_field("right_pwm", want.right_pwm, out_ch.right_pwm);
        check_field("heading_error", want.heading_error, out_ch.heading_error);
      end
    end
  end

  // Result side: long hold-off first, otherwise random stalls
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_off_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Offer one transaction and return the model's answer once it is taken
  task automatic offer(input cmd_t cmd, input logic signed [15:0] meas,
                       input logic [31:0] now_ms, output steer_result_t pred);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid            <= 1'b1;
    in_ch.cmd              <= cmd;
    in_ch.measured_heading <= meas;
    in_ch.now_ms           <= now_ms;
    @(posedge clk);
    while (!in_ch.ready) begin
      @(posedge clk);
    end
    pred = steer_predict(cmd, meas, now_ms);
  endtask

  // Drop valid, let every result come back and the sequencer go quiet
  task automatic settle_bench();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (steer_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_GAP) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [15:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  task automatic apply_settings(input cfg_t c);
    write_reg(REG_TARGET_HEADING, c.target_heading);
    write_reg(REG_TURN_GAIN, c.turn_gain);
    write_reg(REG_DRIVE_LIMIT, 16'(c.drive_limit));
    write_reg(REG_SETTLE_TOLERANCE, 16'(c.settle_tolerance));
    write_reg(REG_SETTLE_LIMIT, 16'(c.settle_limit));
    write_reg(REG_TIMEOUT_MS, c.timeout_ms);
    @(negedge clk);
    cfg_we  <= 1'b0;
    cfg_now = c;
  endtask

  // Turns of samples closing in on the target, with restarts, noise and
  // the odd jump in time that runs a turn past its timeout
  task automatic run_turns(input int n_items, input int step_max,
                           input int restart_pct, input int jump_pct);
    steer_result_t      pred;
    logic signed [15:0] meas;
    logic [31:0]        now_ms;
    int                 spread;
    int                 k;
    now_ms = $urandom;
    spread = 4000;
    for (k = 0; k < n_items; k++) begin
      if (k == 0 || $urandom_range(99) < restart_pct) begin
        spread = $urandom_range(11520, 64);
        offer(CMD_START, 16'($urandom), now_ms, pred);
      end else begin
        if ($urandom_range(99) < jump_pct) begin
          now_ms += $urandom_range(70000);
        end
        if ($urandom_range(9) == 0) begin
          meas = 16'($urandom);
        end else begin
          meas   = 16'(int'(cfg_now.target_heading) +
                       int'($urandom_range(2 * spread)) - spread);
          spread = spread / 2 + 8;
        end
        offer(CMD_SAMPLE, meas, now_ms, pred);
      end
      steer_q.push_back(pred);
      now_ms += $urandom_range(step_max);
    end
  endtask

  function automatic cfg_t random_settings();
    cfg_t c;
    c.target_heading   = 16'($urandom);
    c.turn_gain        = 16'($urandom_range(3000));
    c.drive_limit      = 13'($urandom_range(8191));
    c.settle_tolerance = 14'($urandom_range(11520));
    c.settle_limit     = 8'($urandom_range(30));
    c.timeout_ms       = 16'($urandom_range(5000, 300));
    return c;
  endfunction

  initial begin
    cfg_t          setting;
    steer_result_t pred;
    int            i;
    rst                    = 1'b1;
    cfg_we                 = 1'b0;
    cfg_index              = '0;
    cfg_data               = '0;
    in_ch.valid            = 1'b0;
    in_ch.cmd              = 1'b0;
    in_ch.measured_heading = '0;
    in_ch.now_ms           = '0;
    mismatches             = 0;
    send_idle_pct          = 0;
    recv_stall_pct         = 0;
    hold_off_left          = 0;

    cfg_now.target_heading   = TARGET_HEADING_RST;
    cfg_now.turn_gain        = TURN_GAIN_RST;
    cfg_now.drive_limit      = DRIVE_LIMIT_RST;
    cfg_now.settle_tolerance = SETTLE_TOLERANCE_RST;
    cfg_now.settle_limit     = SETTLE_LIMIT_RST;
    cfg_now.timeout_ms       = TIMEOUT_MS_RST;
    turn_start_ms            = '0;
    on_target_count          = 0;
    turn_state               = PH_IDLE;
    held_left_dir            = DIR_BRAKE;
    held_right_dir           = DIR_BRAKE;
    held_left_pwm            = '0;
    held_right_pwm           = '0;
    held_error               = '0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed rows under the reset settings
    for (i = 0; i < DIRECTED_N; i++) begin
      offer(DIRECTED[i].cmd, DIRECTED[i].meas, DIRECTED[i].now_ms, pred);
      steer_q.push_back(DIRECTED[i].typed ? DIRECTED[i].want : pred);
    end
    settle_bench();

    // Ordinary turns, no idling
    setting                = random_settings();
    setting.turn_gain      = TURN_GAIN_RST;
    setting.drive_limit    = DRIVE_LIMIT_RST;
    setting.settle_limit   = SETTLE_LIMIT_RST;
    setting.timeout_ms     = TIMEOUT_MS_RST;
    setting.settle_tolerance = SETTLE_TOLERANCE_RST;
    apply_settings(setting);
    run_turns(120, 40, 6, 4);
    settle_bench();

    // Extremes: full gain, oversized limit, settle at once, zero timeout
    setting.target_heading   = -16'sd32768;
    setting.turn_gain        = 16'hFFFF;
    setting.drive_limit      = 13'h1FFF;
    setting.settle_tolerance = 14'd11520;
    setting.settle_limit     = 8'd0;
    setting.timeout_ms       = 16'd0;
    apply_settings(setting);
    send_idle_pct = 81;
    run_turns(80, 1, 20, 0);
    settle_bench();

    // Other extremes: no gain, no drive, never on target, longest timeout
    setting.target_heading   = 16'sd32767;
    setting.turn_gain        = 16'd0;
    setting.drive_limit      = 13'd0;
    setting.settle_tolerance = 14'd0;
    setting.settle_limit     = 8'd255;
    setting.timeout_ms       = 16'hFFFF;
    apply_settings(setting);
    send_idle_pct  = 0;
    recv_stall_pct = 81;
    run_turns(80, 50, 6, 10);
    settle_bench();

    // One long turn so the on-target count saturates and never settles
    setting                  = random_settings();
    setting.drive_limit      = 13'd4096;
    setting.settle_tolerance = 14'd11520;
    setting.settle_limit     = 8'd255;
    setting.timeout_ms       = 16'hFFFF;
    apply_settings(setting);
    send_idle_pct  = 24;
    recv_stall_pct = 24;
    run_turns(300, 3, 0, 0);
    settle_bench();

    // Hold the result side off so the block backs up into its input
    apply_settings(random_settings());
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_left  = 300;
    run_turns(60, 40, 8, 4);
    settle_bench();

    apply_settings(random_settings());
    recv_stall_pct = 81;
    run_turns(80, 60, 8, 6);
    settle_bench();

    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
